FILE: hdl/lzmf_pkg.sv
// ----------------------------------------------------------------------------
// lzmf_pkg
// shared types and fixed datapath widths of the local zernike moment filter
// ----------------------------------------------------------------------------
`default_nettype none

package lzmf_pkg;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_KERNEL  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_WINDOW  = 2'd2,
    CFG_MOMENTS = 2'd3
  } cfg_idx_t;

  // widths sized for windows up to 15 x 15
  localparam int SUM_W  = 16;
  localparam int SQ_W   = 24;
  localparam int Q_W    = 32;
  localparam int V_W    = 48;
  localparam int R_W    = 24;
  localparam int DEN_W  = 42;
  localparam int D_W    = 17;
  localparam int P_W    = 33;
  localparam int ACC_W  = 42;
  localparam int A_W    = 47;
  localparam int FRAC_N = 30;
  localparam int DIV_N  = A_W + FRAC_N;
  localparam int QF_W   = 35;

  localparam logic [17:0] PI_Q16 = 18'd205887;

endpackage

`default_nettype wire

FILE: hdl/local_zernike_moment_filter.sv
// ----------------------------------------------------------------------------
// local_zernike_moment_filter
// image and kernel stores with a read-modify sequencer for local zernike moments
// ----------------------------------------------------------------------------
// Loads (pixel or kernel tap) are accepted only while the sequencer is idle. A
// compute request walks the window once through the image memory for sum and
// sum of squares, then computes the variance, square root and denominator, then
// for each active moment walks the window through the image and kernel memories
// and runs two bit-serial dividers in parallel before the result transfer.
// A flat window skips the per-moment walk and division. The single read port of
// the image memory sets the walk rate of one tap per cycle.
`default_nettype none

module local_zernike_moment_filter #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int MAX_WINDOW  = 9,
  parameter int MAX_MOMENTS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // row, col, pixel_value, moment_slot, tap_index, coef_real, coef_imag, moment_order
  input  wire logic [71:0] in_tdata,
  // opcode
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_row, out_col, out_moment, moment_real, moment_imag, zero pad
  output logic [87:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata
);

  localparam int NTAPS = MAX_WINDOW * MAX_WINDOW;
  localparam int IAW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int KAW   = $clog2(MAX_MOMENTS * NTAPS);
  localparam int MIW   = (MAX_MOMENTS > 1) ? $clog2(MAX_MOMENTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_STAT, S_QMUL, S_QSUB, S_SQRT, S_DEN, S_MOM, S_DIV, S_EMIT
  } state_t;

  state_t state_r;

  logic [8:0] width_r, height_r;
  logic [3:0] wsize_r;
  logic [4:0] nmom_r;

  logic [7:0]  row_r, col_r;
  logic [12:0] w_r, h_r;
  logic [3:0]  step_r, side_r;
  logic [7:0]  n_r;
  logic [4:0]  cnt_r;

  logic       walk_r;
  logic [3:0] y_r, x_r;
  logic [7:0] t_r;
  logic       v1_r, v2_r, v3_r;

  logic [7:0]  pix_q;
  logic [31:0] kq;

  logic [lzmf_pkg::SUM_W-1:0] sum_r;
  logic [lzmf_pkg::SQ_W-1:0]  sumsq_r;
  logic [lzmf_pkg::Q_W-1:0]   p1_r, p2_r;
  logic [lzmf_pkg::V_W-1:0]   sv_r, sres_r, sbit_r;
  logic [lzmf_pkg::DEN_W-1:0] den_r;
  logic                       flat_r;

  logic signed [lzmf_pkg::D_W-1:0]   d_r;
  logic signed [15:0]                kre_r, kim_r;
  logic signed [lzmf_pkg::P_W-1:0]   pre_r, pim_r;
  logic signed [lzmf_pkg::ACC_W-1:0] cre_r, cim_r;

  logic [4:0]     k_r;
  logic [KAW-1:0] kbase_r;

  logic                        neg_re_r, neg_im_r, ov_re_r, ov_im_r;
  logic [lzmf_pkg::DIV_N-1:0]  dre_r, dim_r;
  logic [lzmf_pkg::DEN_W-1:0]  rre_r, rim_r;
  logic [lzmf_pkg::QF_W-1:0]   qre_r, qim_r;
  logic [6:0]                  dcnt_r;

  logic [3:0] order_r [MAX_MOMENTS];
  logic [7:0]  img_mem [MAX_WIDTH * MAX_HEIGHT];
  logic [31:0] ker_mem [MAX_MOMENTS * NTAPS];

  logic        out_valid_r, out_last_r;
  logic [7:0]  out_row_r, out_col_r;
  logic [4:0]  out_mom_r;
  logic [31:0] out_re_r, out_im_r;

  // input fields
  logic [7:0]  f_row, f_col, f_pix;
  logic [4:0]  f_slot;
  logic [6:0]  f_tap;
  logic [31:0] f_coef;
  logic [3:0]  f_order;
  logic        in_xfer;

  assign f_row   = in_tdata[7:0];
  assign f_col   = in_tdata[15:8];
  assign f_pix   = in_tdata[23:16];
  assign f_slot  = in_tdata[28:24];
  assign f_tap   = in_tdata[35:29];
  assign f_coef  = {in_tdata[51:36], in_tdata[67:52]};
  assign f_order = in_tdata[71:68];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  function automatic logic [11:0] fold(input logic signed [13:0] v, input logic [12:0] len);
    logic signed [14:0] t;
    logic signed [14:0] l;
    l = $signed({2'b00, len});
    if (v < 0) begin
      t = -15'(v) - 15'sd1;
    end else if (15'(v) >= l) begin
      t = (l <<< 1) - 15'(v) - 15'sd1;
    end else begin
      t = 15'(v);
    end
    if (t < 0) t = 15'sd0;
    if (t >= l) t = l - 15'sd1;
    return t[11:0];
  endfunction

  function automatic logic [lzmf_pkg::DEN_W:0] dstep(input logic [lzmf_pkg::DEN_W-1:0] rem,
                                                     input logic inb,
                                                     input logic [lzmf_pkg::DEN_W-1:0] den);
    logic [lzmf_pkg::DEN_W:0] sh;
    logic [lzmf_pkg::DEN_W:0] df;
    sh = {rem, inb};
    df = sh - {1'b0, den};
    if (sh >= {1'b0, den}) return {1'b1, df[lzmf_pkg::DEN_W-1:0]};
    return {1'b0, sh[lzmf_pkg::DEN_W-1:0]};
  endfunction

  function automatic logic [31:0] finish(input logic [lzmf_pkg::QF_W-1:0] q, input logic ov,
                                         input logic neg);
    logic [lzmf_pkg::QF_W:0]   qp;
    logic [lzmf_pkg::QF_W-1:0] r;
    logic [31:0]               cap;
    logic [31:0]               res;
    qp  = {1'b0, q} + 1'b1;
    r   = qp[lzmf_pkg::QF_W:1];
    cap = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    if (ov || r > {3'b000, cap}) res = cap;
    else res = r[31:0];
    return neg ? 32'd0 - res : res;
  endfunction

  // window address generation
  logic signed [13:0] vy, vx;
  logic [11:0]        ia, ja;
  logic [IAW-1:0]     img_raddr;
  logic [KAW-1:0]     ker_raddr;

  assign vy = $signed({6'b0, row_r}) + $signed({10'b0, y_r}) - $signed({10'b0, step_r});
  assign vx = $signed({6'b0, col_r}) + $signed({10'b0, x_r}) - $signed({10'b0, step_r});
  assign ia = fold(vy, h_r);
  assign ja = fold(vx, w_r);
  assign img_raddr = IAW'(ia * MAX_WIDTH + ja);
  assign ker_raddr = KAW'(kbase_r + t_r);

  // request clamping
  logic [3:0] ws_c, st_c, side_c;
  logic [4:0] cnt_c;
  always_comb begin
    ws_c = (wsize_r > MAX_WINDOW) ? 4'(MAX_WINDOW) : wsize_r;
    st_c = ws_c >> 1;
    if ({st_c, 1'b1} > MAX_WINDOW) st_c = st_c - 4'd1;
    side_c = {st_c[2:0], 1'b1};
    cnt_c = (nmom_r > MAX_MOMENTS) ? 5'(MAX_MOMENTS) : nmom_r;
  end

  // memories
  logic img_we, ker_we;
  assign img_we = in_xfer && (in_tuser == lzmf_pkg::OP_PIXEL)
                  && (f_row < MAX_HEIGHT) && (f_col < MAX_WIDTH);
  assign ker_we = in_xfer && (in_tuser == lzmf_pkg::OP_KERNEL)
                  && (f_slot < MAX_MOMENTS) && (f_tap < NTAPS);

  always_ff @(posedge clk) begin
    if (img_we) img_mem[IAW'(f_row * MAX_WIDTH + f_col)] <= f_pix;
    pix_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (ker_we) begin
      ker_mem[KAW'(f_slot * NTAPS + f_tap)] <= f_coef;
      order_r[MIW'(f_slot)] <= f_order;
    end
    kq <= ker_mem[ker_raddr];
  end

  // datapath helpers
  logic signed [lzmf_pkg::D_W-1:0]   d_nxt;
  logic [lzmf_pkg::Q_W-1:0]          q_c;
  logic [lzmf_pkg::V_W-1:0]          srb;
  logic [lzmf_pkg::ACC_W-1:0]        mre, mim;
  logic [4:0]                        factor;
  logic [lzmf_pkg::DEN_W:0]          stre, stim;
  logic                              pipe_busy;

  assign d_nxt  = $signed({1'b0, 16'(16'(n_r) * 16'(pix_q))}) - $signed({1'b0, sum_r});
  assign q_c    = p1_r - p2_r;
  assign srb    = sres_r + sbit_r;
  assign mre    = cre_r[lzmf_pkg::ACC_W-1] ? lzmf_pkg::ACC_W'(-cre_r) : lzmf_pkg::ACC_W'(cre_r);
  assign mim    = cim_r[lzmf_pkg::ACC_W-1] ? lzmf_pkg::ACC_W'(-cim_r) : lzmf_pkg::ACC_W'(cim_r);
  assign factor = {1'b0, order_r[k_r[MIW-1:0]]} + 5'd1;
  assign stre   = dstep(rre_r, dre_r[lzmf_pkg::DIV_N-1], den_r);
  assign stim   = dstep(rim_r, dim_r[lzmf_pkg::DIV_N-1], den_r);
  assign pipe_busy = walk_r || v1_r || v2_r || v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= 9'd64;
      height_r    <= 9'd64;
      wsize_r     <= 4'd5;
      nmom_r      <= 5'd6;
      walk_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (lzmf_pkg::cfg_idx_t'(cfg_index))
          lzmf_pkg::CFG_WIDTH:   width_r  <= cfg_wdata;
          lzmf_pkg::CFG_HEIGHT:  height_r <= cfg_wdata;
          lzmf_pkg::CFG_WINDOW:  wsize_r  <= cfg_wdata[3:0];
          lzmf_pkg::CFG_MOMENTS: nmom_r   <= cfg_wdata[4:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      // window walk
      if (walk_r) begin
        t_r <= t_r + 8'd1;
        if (x_r == side_r - 4'd1) begin
          x_r <= 4'd0;
          if (y_r == side_r - 4'd1) walk_r <= 1'b0;
          else y_r <= y_r + 4'd1;
        end else begin
          x_r <= x_r + 4'd1;
        end
      end
      v1_r <= walk_r;
      v2_r <= v1_r && (state_r == S_MOM);
      v3_r <= v2_r;

      if (v1_r && state_r == S_STAT) begin
        sum_r   <= sum_r + lzmf_pkg::SUM_W'(pix_q);
        sumsq_r <= sumsq_r + lzmf_pkg::SQ_W'(16'(pix_q) * 16'(pix_q));
      end
      if (v1_r) begin
        d_r   <= d_nxt;
        kre_r <= kq[31:16];
        kim_r <= kq[15:0];
      end
      if (v2_r) begin
        pre_r <= d_r * kre_r;
        pim_r <= d_r * kim_r;
      end
      if (v3_r) begin
        cre_r <= cre_r + lzmf_pkg::ACC_W'(pre_r);
        cim_r <= cim_r - lzmf_pkg::ACC_W'(pim_r);
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && in_tuser == lzmf_pkg::OP_COMPUTE && cnt_c != 5'd0) begin
            row_r   <= f_row;
            col_r   <= f_col;
            w_r     <= (width_r == 9'd0) ? 13'd1 :
                       ((width_r > MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(width_r));
            h_r     <= (height_r == 9'd0) ? 13'd1 :
                       ((height_r > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : 13'(height_r));
            step_r  <= st_c;
            side_r  <= side_c;
            n_r     <= 8'(side_c * side_c);
            cnt_r   <= cnt_c;
            sum_r   <= '0;
            sumsq_r <= '0;
            walk_r  <= 1'b1;
            x_r     <= 4'd0;
            y_r     <= 4'd0;
            t_r     <= 8'd0;
            state_r <= S_STAT;
          end
        end
        S_STAT: begin
          if (!pipe_busy) state_r <= S_QMUL;
        end
        S_QMUL: begin
          p1_r    <= lzmf_pkg::Q_W'(n_r * sumsq_r);
          p2_r    <= lzmf_pkg::Q_W'(sum_r * sum_r);
          state_r <= S_QSUB;
        end
        S_QSUB: begin
          k_r     <= 5'd0;
          kbase_r <= '0;
          if (q_c == '0) begin
            flat_r  <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            flat_r  <= 1'b0;
            sv_r    <= {q_c, 16'b0};
            sres_r  <= '0;
            sbit_r  <= lzmf_pkg::V_W'(1) << (lzmf_pkg::V_W - 2);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sbit_r == '0) begin
            state_r <= S_DEN;
          end else begin
            if (sv_r >= srb) begin
              sv_r   <= sv_r - srb;
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end
        S_DEN: begin
          den_r   <= lzmf_pkg::DEN_W'(sres_r[lzmf_pkg::R_W-1:0] * lzmf_pkg::PI_Q16);
          cre_r   <= '0;
          cim_r   <= '0;
          walk_r  <= 1'b1;
          x_r     <= 4'd0;
          y_r     <= 4'd0;
          t_r     <= 8'd0;
          state_r <= S_MOM;
        end
        S_MOM: begin
          if (!pipe_busy) begin
            neg_re_r <= cre_r[lzmf_pkg::ACC_W-1];
            neg_im_r <= cim_r[lzmf_pkg::ACC_W-1];
            dre_r    <= {lzmf_pkg::A_W'(mre * factor), lzmf_pkg::FRAC_N'(0)};
            dim_r    <= {lzmf_pkg::A_W'(mim * factor), lzmf_pkg::FRAC_N'(0)};
            rre_r    <= '0;
            rim_r    <= '0;
            qre_r    <= '0;
            qim_r    <= '0;
            ov_re_r  <= 1'b0;
            ov_im_r  <= 1'b0;
            dcnt_r   <= 7'd0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          dre_r   <= dre_r << 1;
          dim_r   <= dim_r << 1;
          rre_r   <= stre[lzmf_pkg::DEN_W-1:0];
          rim_r   <= stim[lzmf_pkg::DEN_W-1:0];
          qre_r   <= {qre_r[lzmf_pkg::QF_W-2:0], stre[lzmf_pkg::DEN_W]};
          qim_r   <= {qim_r[lzmf_pkg::QF_W-2:0], stim[lzmf_pkg::DEN_W]};
          ov_re_r <= ov_re_r | qre_r[lzmf_pkg::QF_W-1];
          ov_im_r <= ov_im_r | qim_r[lzmf_pkg::QF_W-1];
          dcnt_r  <= dcnt_r + 7'd1;
          if (dcnt_r == 7'(lzmf_pkg::DIV_N - 1)) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_row_r   <= row_r;
            out_col_r   <= col_r;
            out_mom_r   <= k_r;
            out_last_r  <= (k_r == cnt_r - 5'd1);
            out_re_r    <= flat_r ? 32'd0 : finish(qre_r, ov_re_r, neg_re_r);
            out_im_r    <= flat_r ? 32'd0 : finish(qim_r, ov_im_r, neg_im_r);
            if (k_r == cnt_r - 5'd1) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 5'd1;
              kbase_r <= KAW'(kbase_r + NTAPS);
              if (!flat_r) begin
                cre_r   <= '0;
                cim_r   <= '0;
                walk_r  <= 1'b1;
                x_r     <= 4'd0;
                y_r     <= 4'd0;
                t_r     <= 8'd0;
                state_r <= S_MOM;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_im_r, out_re_r, out_mom_r, out_col_r, out_row_r};

endmodule

`default_nettype wire
